// ===== rtl/ptd_pkg.sv =====
// Shared types, codes and field widths of the periodic task dispatcher.
package ptd_pkg;

  localparam int FUNC_W = 3;
  localparam int ID_W   = 8;
  localparam int PREQ_W = 4;
  localparam int PER_W  = 16;
  localparam int STAT_W = 3;

  typedef enum logic [FUNC_W-1:0] {
    FN_TICK     = 3'd0,
    FN_ADD_PER  = 3'd1,
    FN_ADD_ONE  = 3'd2,
    FN_REMOVE   = 3'd3,
    FN_DISPATCH = 3'd4
  } ptd_func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 3'd0,
    ST_INVALID    = 3'd1,
    ST_DUPLICATE  = 3'd2,
    ST_FULL       = 3'd3,
    ST_NOT_FOUND  = 3'd4,
    ST_DISPATCHED = 3'd5,
    ST_NONE_READY = 3'd6
  } ptd_status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // latch the incoming item, restart the priority scan
    logic exec;       // apply a single-result command and push its result
    logic disp_emit;  // push the selected ready task and clear its marks
    logic none_emit;  // push the nothing-ready result
    logic prio_adv;   // move the dispatch scan to the next priority
  } ptd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_is_disp; // incoming item is a dispatch
    logic any_ready;  // some active slot is ready
    logic hit;        // a ready slot sits at the scanned priority
    logic others;     // more ready slots remain besides the selected one
    logic out_free;   // output register can take a result this cycle
  } ptd_stat_t;

endpackage

// ===== rtl/ptd_if.sv =====
// Valid/ready channel interfaces for command items and result items.
interface ptd_in_if import ptd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ID_W-1:0]   task_id;
  logic [PREQ_W-1:0] priority_req;
  logic [PER_W-1:0]  period;

  modport source (output valid, func, task_id, priority_req, period, input ready);
  modport sink   (input valid, func, task_id, priority_req, period, output ready);
endinterface

interface ptd_out_if import ptd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ID_W-1:0]   task_id_out;
  logic              missed;
  logic              last;

  modport source (output valid, status, task_id_out, missed, last, input ready);
  modport sink   (input valid, status, task_id_out, missed, last, output ready);
endinterface

// ===== rtl/ptd_ctrl.sv =====
// Sequencer of the task dispatcher: accepts items and steps commands and dispatch scans.
module ptd_ctrl import ptd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ptd_stat_t stat_i,
  output ptd_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DISP
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = stat_i.in_is_disp ? S_DISP : S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_DISP: begin
        if (!stat_i.any_ready) begin
          if (stat_i.out_free) begin
            cmd_o.none_emit = 1'b1;
            state_d         = S_IDLE;
          end
        end else if (stat_i.hit) begin
          if (stat_i.out_free) begin
            cmd_o.disp_emit = 1'b1;
            if (!stat_i.others) begin
              state_d = S_IDLE;
            end
          end
        end else begin
          cmd_o.prio_adv = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/ptd_dp.sv =====
// Datapath of the task dispatcher: slot table, command decode and result register.
module ptd_dp import ptd_pkg::*; #(
  parameter int TASK_SLOTS      = 8,
  parameter int PRIORITY_LEVELS = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [FUNC_W-1:0] in_func_i,
  input  logic [ID_W-1:0]   in_task_id_i,
  input  logic [PREQ_W-1:0] in_priority_req_i,
  input  logic [PER_W-1:0]  in_period_i,
  input  ptd_cmd_t          cmd_i,
  output ptd_stat_t         stat_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [STAT_W-1:0] out_status_o,
  output logic [ID_W-1:0]   out_task_id_o,
  output logic              out_missed_o,
  output logic              out_last_o
);

  localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int PW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
  localparam logic [PREQ_W:0] PRIO_LIMIT = (PREQ_W+1)'(PRIORITY_LEVELS);

  // Latched command item
  logic [FUNC_W-1:0] func_q;
  logic [ID_W-1:0]   id_q;
  logic [PREQ_W-1:0] preq_q;
  logic [PER_W-1:0]  per_q;

  // Slot cells
  logic [TASK_SLOTS-1:0] act_q, act_d;
  logic [TASK_SLOTS-1:0] rdy_q, rdy_d;
  logic [TASK_SLOTS-1:0] mis_q, mis_d;
  logic [TASK_SLOTS-1:0] one_q, one_d;
  logic [ID_W-1:0]  sid_q [TASK_SLOTS];
  logic [ID_W-1:0]  sid_d [TASK_SLOTS];
  logic [PW-1:0]    spri_q [TASK_SLOTS];
  logic [PW-1:0]    spri_d [TASK_SLOTS];
  logic [PER_W-1:0] sper_q [TASK_SLOTS];
  logic [PER_W-1:0] sper_d [TASK_SLOTS];
  logic [PER_W-1:0] scnt_q [TASK_SLOTS];
  logic [PER_W-1:0] scnt_d [TASK_SLOTS];
  logic [PER_W-1:0] cnt_inc;

  logic [PW-1:0] scan_p_q;

  // Result register
  logic              ovalid_q;
  logic [STAT_W-1:0] ostat_q, ostat_d;
  logic [ID_W-1:0]   oid_q, oid_d;
  logic              omis_q, omis_d;
  logic              olast_q, olast_d;
  logic              push;

  // Slot searches
  logic [TASK_SLOTS-1:0] match, rdy_act, cand;
  logic [IW-1:0]         free_idx, match_idx, sel_idx;
  logic                  any_free, any_match, fill, others;
  logic [PW-1:0]         fill_pri;
  logic                  fill_one;

  always_comb begin
    free_idx  = '0;
    match_idx = '0;
    sel_idx   = '0;
    others    = 1'b0;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      match[i]   = act_q[i] && (sid_q[i] == id_q);
      rdy_act[i] = act_q[i] && rdy_q[i];
      cand[i]    = rdy_act[i] && (spri_q[i] == scan_p_q);
    end
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (!act_q[i]) free_idx = IW'(i);
      if (match[i])  match_idx = IW'(i);
      if (cand[i])   sel_idx = IW'(i);
    end
    for (int i = 0; i < TASK_SLOTS; i++) begin
      if (rdy_act[i] && (IW'(i) != sel_idx)) others = 1'b1;
    end
    any_free  = ~&act_q;
    any_match = |match;
  end

  assign push = cmd_i.exec || cmd_i.disp_emit || cmd_i.none_emit;

  assign stat_o.in_is_disp = (in_func_i == FN_DISPATCH);
  assign stat_o.any_ready  = |rdy_act;
  assign stat_o.hit        = |cand;
  assign stat_o.others     = others;
  assign stat_o.out_free   = !ovalid_q || out_ready_i;

  always_comb begin
    act_d    = act_q;
    rdy_d    = rdy_q;
    mis_d    = mis_q;
    one_d    = one_q;
    sid_d    = sid_q;
    spri_d   = spri_q;
    sper_d   = sper_q;
    scnt_d   = scnt_q;
    ostat_d  = ostat_q;
    oid_d    = oid_q;
    omis_d   = omis_q;
    olast_d  = olast_q;
    fill     = 1'b0;
    fill_pri = '0;
    fill_one = 1'b0;
    cnt_inc  = '0;

    if (cmd_i.exec) begin
      oid_d   = '0;
      omis_d  = 1'b0;
      olast_d = 1'b1;
      ostat_d = ST_OK;
      case (func_q)
        FN_TICK: begin
          for (int i = 0; i < TASK_SLOTS; i++) begin
            cnt_inc = scnt_q[i] + PER_W'(1);
            if (act_q[i]) begin
              scnt_d[i] = cnt_inc;
              if (cnt_inc >= sper_q[i]) begin
                if (rdy_q[i]) mis_d[i] = 1'b1;
                scnt_d[i] = '0;
                rdy_d[i]  = 1'b1;
              end
            end
          end
        end
        FN_ADD_PER: begin
          if ((id_q == '0) || ({1'b0, preq_q} >= PRIO_LIMIT)) begin
            ostat_d = ST_INVALID;
          end else if (any_match) begin
            ostat_d = ST_DUPLICATE;
          end else if (!any_free) begin
            ostat_d = ST_FULL;
          end else begin
            fill     = 1'b1;
            fill_pri = preq_q[PW-1:0];
          end
        end
        FN_ADD_ONE: begin
          if (id_q == '0) begin
            ostat_d = ST_INVALID;
          end else if (!any_free) begin
            ostat_d = ST_FULL;
          end else begin
            fill     = 1'b1;
            fill_one = 1'b1;
          end
        end
        FN_REMOVE: begin
          if (any_match) begin
            act_d[match_idx] = 1'b0;
          end else begin
            ostat_d = ST_NOT_FOUND;
          end
        end
        default: begin
          ostat_d = ST_INVALID;
        end
      endcase
    end

    // Take the lowest free slot with fresh marks.
    if (fill) begin
      act_d[free_idx]  = 1'b1;
      sid_d[free_idx]  = id_q;
      spri_d[free_idx] = fill_pri;
      sper_d[free_idx] = per_q;
      scnt_d[free_idx] = '0;
      rdy_d[free_idx]  = 1'b0;
      mis_d[free_idx]  = 1'b0;
      one_d[free_idx]  = fill_one;
    end

    if (cmd_i.disp_emit) begin
      ostat_d = ST_DISPATCHED;
      oid_d   = sid_q[sel_idx];
      omis_d  = mis_q[sel_idx];
      olast_d = !others;
      rdy_d[sel_idx] = 1'b0;
      mis_d[sel_idx] = 1'b0;
      if (one_q[sel_idx]) act_d[sel_idx] = 1'b0;
    end

    if (cmd_i.none_emit) begin
      ostat_d = ST_NONE_READY;
      oid_d   = '0;
      omis_d  = 1'b0;
      olast_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q    <= '0;
      ovalid_q <= 1'b0;
      scan_p_q <= '0;
    end else begin
      act_q <= act_d;
      if (push) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
      if (cmd_i.load) begin
        scan_p_q <= '0;
      end else if (cmd_i.prio_adv) begin
        scan_p_q <= scan_p_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= in_func_i;
      id_q   <= in_task_id_i;
      preq_q <= in_priority_req_i;
      per_q  <= in_period_i;
    end
    rdy_q   <= rdy_d;
    mis_q   <= mis_d;
    one_q   <= one_d;
    sid_q   <= sid_d;
    spri_q  <= spri_d;
    sper_q  <= sper_d;
    scnt_q  <= scnt_d;
    ostat_q <= ostat_d;
    oid_q   <= oid_d;
    omis_q  <= omis_d;
    olast_q <= olast_d;
  end

  assign out_valid_o   = ovalid_q;
  assign out_status_o  = ostat_q;
  assign out_task_id_o = oid_q;
  assign out_missed_o  = omis_q;
  assign out_last_o    = olast_q;

`ifndef SYNTHESIS
  // A result never overwrites one that is still waiting.
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (!ovalid_q || out_ready_i))
    else $error("result pushed over a pending result");

  // Each dispatched task leaves the ready set.
  a_disp_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.disp_emit |=> ($countones(rdy_act) < $past($countones(rdy_act))))
    else $error("dispatched task still ready");

  // The nothing-ready result only when the table holds no ready task.
  a_none_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.none_emit |-> (rdy_act == '0))
    else $error("nothing-ready result with a ready task");

  // Only dispatched results carry a missed mark.
  a_missed_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && omis_q) |-> (ostat_q == ST_DISPATCHED))
    else $error("missed mark on a non-dispatch result");
`endif

endmodule

// ===== rtl/periodic_task_dispatcher_top.sv =====
// Top level of the periodic task dispatcher: command channel in, result channel out.
//
//   channel | dir | handshake      | payload
//   --------+-----+----------------+------------------------------------------
//   in_i    | in  | valid / ready  | func, task_id, priority_req, period
//   out_o   | out | valid / ready  | status, task_id_out, missed, last
//
// Sequencing: one item at a time. Tick, add, remove and unused codes are accepted,
// then update the table and push their result. Dispatch is accepted, then scans the
// priority levels in order, stepping over empty levels, and emits one ready task at a
// time, each waiting while the output register is full. The scan stops after the last
// ready task, so at most PRIORITY_LEVELS - 1 empty levels are scanned.
// Reset clears the slot active bits, the sequencer, the scan priority and the result valid bit.
// A stalled result holds in the output register; a new item is taken while it waits.
module periodic_task_dispatcher_top import ptd_pkg::*; #(
  parameter int TASK_SLOTS      = 8,
  parameter int PRIORITY_LEVELS = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  ptd_in_if.sink    in_i,
  ptd_out_if.source out_o
);

  ptd_cmd_t  cmd;
  ptd_stat_t stat;

  // Sequencer: owns the input handshake and steps the datapath.
  ptd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath: slot table, searches and the result register.
  ptd_dp #(
    .TASK_SLOTS      (TASK_SLOTS),
    .PRIORITY_LEVELS (PRIORITY_LEVELS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_func_i         (in_i.func),
    .in_task_id_i      (in_i.task_id),
    .in_priority_req_i (in_i.priority_req),
    .in_period_i       (in_i.period),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .out_valid_o       (out_o.valid),
    .out_ready_i       (out_o.ready),
    .out_status_o      (out_o.status),
    .out_task_id_o     (out_o.task_id_out),
    .out_missed_o      (out_o.missed),
    .out_last_o        (out_o.last)
  );

endmodule
